### hw/rtl/lj_shifted_force_pair_macros.svh
// Assertion macros shared by the shifted-force pair evaluator.
`ifndef LJ_SHIFTED_FORCE_PAIR_MACROS_SVH
`define LJ_SHIFTED_FORCE_PAIR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LJSF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define LJSF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ljsf_pkg.sv
// Shared types, constants and helper functions for the shifted-force pair evaluator.
package ljsf_pkg;

    localparam int DIST_W   = 24;
    localparam int EPS_W    = 32;
    localparam int OUT_W    = 32;
    localparam int IDX_W    = 3;
    localparam int DIST_FRAC = 18;
    localparam int OUT_FRAC  = 16;
    localparam int E_SHIFT   = 56 - OUT_FRAC;
    localparam int F_SHIFT   = 56 - OUT_FRAC - DIST_FRAC;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SIGMA = 3'd0;
    localparam logic [IDX_W-1:0] REG_EPS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_RCUT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_UCUT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FCUT  = 3'd4;

    localparam logic [DIST_W-1:0] SIGMA_RST = 24'd262144;
    localparam logic [EPS_W-1:0]  EPS_RST   = 32'd16777216;
    localparam logic [DIST_W-1:0] RCUT_RST  = 24'd655360;

    // divider: quotient bits per pass and remainder/divisor width
    localparam int QW = 36;
    localparam int RW = DIST_W + F_SHIFT;

    // wide multiplier
    localparam int MUL_W   = 64;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int HALF_W  = MUL_W / 2;
    localparam int MUL_LAT = 2;

    localparam int MAG_W = 51;
    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << 50;
    localparam int FMAG_W = QW + 1;

    localparam logic [PROD_W-1:0] Q32_HALF = PROD_W'(1) << 31;
    localparam logic [PROD_W-1:0] E_HALF   = PROD_W'(1) << (E_SHIFT - 1);
    localparam int TPROD_W = DIST_W + OUT_W;
    localparam logic [TPROD_W:0] T_HALF = (TPROD_W + 1)'(1) << (DIST_FRAC - 1);

    localparam int SUM_W = 56;

    typedef struct packed {
        logic [DIST_W-1:0] r;
        logic              beyond;
        logic              zero;
        logic              ovf;
        logic signed [39:0] term;
        logic              uneg;
        logic              fneg;
        logic [MAG_W-1:0]  umag;
        logic              big2;
    } side_t;

    typedef struct packed {
        logic              sat;
        logic signed [OUT_W-1:0] val;
    } clip_t;

    // clip a wide signed sum to 32 bits, flag a clip
    function automatic clip_t sat32(input logic signed [SUM_W-1:0] v);
        clip_t c;
        if (v > 56'sd2147483647) begin
            c.sat = 1'b1;
            c.val = 32'sh7FFFFFFF;
        end else if (v < -56'sd2147483648) begin
            c.sat = 1'b1;
            c.val = 32'sh80000000;
        end else begin
            c.sat = 1'b0;
            c.val = v[OUT_W-1:0];
        end
        return c;
    endfunction

endpackage

### hw/rtl/ljsf_mul.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module ljsf_mul
    import ljsf_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [MUL_W-1:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // register partial products
    always_ff @(posedge clk)
    begin
        pp00_reg <= a[HALF_W-1:0] * b[HALF_W-1:0];
        pp01_reg <= a[HALF_W-1:0] * b[MUL_W-1:HALF_W];
        pp10_reg <= a[MUL_W-1:HALF_W] * b[HALF_W-1:0];
        pp11_reg <= a[MUL_W-1:HALF_W] * b[MUL_W-1:HALF_W];
    end

    // align and sum
    always_comb
    begin
        prod_next = PROD_W'(pp00_reg)
                  + (PROD_W'(pp01_reg) << HALF_W)
                  + (PROD_W'(pp10_reg) << HALF_W)
                  + {pp11_reg, {MUL_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/ljsf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ljsf_div
    import ljsf_pkg::*;
(
    input  logic          clk,
    input  logic [RW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [RW-1:0] den_in,
    output logic [QW-1:0] quo_out,
    output logic [RW-1:0] rem_out
);

    logic [RW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [RW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [RW-1:0] rp;
        logic [QW-1:0] lp;
        logic [RW-1:0] dp;
        logic [QW-1:0] qp;
        logic [RW:0]   trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rp = rem_in;
            assign lp = low_in;
            assign dp = den_in;
            assign qp = '0;
        end
        else
        begin : g_next
            assign rp = rem_reg[k-1];
            assign lp = low_reg[k-1];
            assign dp = den_reg[k-1];
            assign qp = quo_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign trial = {rp, lp[QW-1]};
        assign ge    = trial >= {1'b0, dp};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? RW'(trial - {1'b0, dp}) : RW'(trial);
            low_reg[k] <= lp << 1;
            den_reg[k] <= dp;
            quo_reg[k] <= {qp[QW-2:0], ge};
        end
    end

    assign quo_out = quo_reg[QW-1];
    assign rem_out = rem_reg[QW-1];

endmodule

### hw/rtl/lj_shifted_force_pair.sv
// Shifted-force Lennard-Jones 12-6 pair evaluator, top level.
// Throughput: one transaction per cycle; busy stays low, a new distance enters every cycle.
// The depth is set by the two 36-stage dividers (sigma/r and the force quotient).
// Reset clears configuration to defaults and drops all in-flight transactions.
// done is high for exactly one cycle per result; the receiver cannot stall.
`include "lj_shifted_force_pair_macros.svh"

module lj_shifted_force_pair
    import ljsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DIST_W-1:0]       pair_dist,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_index,
    input  logic [OUT_W-1:0]        wr_data,
    output logic                    done,
    output logic signed [OUT_W-1:0] energy_out,
    output logic signed [OUT_W-1:0] force_out,
    output logic                    beyond_cut,
    output logic                    saturated
);

    // pipeline stage positions
    localparam int ST_Q   = QW;
    localparam int ST_S2  = ST_Q + MUL_LAT + 1;
    localparam int ST_S4  = ST_S2 + MUL_LAT + 1;
    localparam int ST_S6  = ST_S4 + MUL_LAT + 1;
    localparam int ST_S12 = ST_S6 + MUL_LAT + 1;
    localparam int ST_DG  = ST_S12 + 1;
    localparam int ST_N   = ST_DG + MUL_LAT + 1;
    localparam int ST_F   = ST_N + QW;
    localparam int DLY    = MUL_LAT + 1;

    // configuration registers
    logic [DIST_W-1:0]       sigma_reg;
    logic [EPS_W-1:0]        eps_reg;
    logic [DIST_W-1:0]       rcut_reg;
    logic signed [OUT_W-1:0] ucut_reg;
    logic signed [OUT_W-1:0] fcut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RST;
            eps_reg   <= EPS_RST;
            rcut_reg  <= RCUT_RST;
            ucut_reg  <= '0;
            fcut_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SIGMA: sigma_reg <= wr_data[DIST_W-1:0];
                REG_EPS:   eps_reg   <= wr_data;
                REG_RCUT:  rcut_reg  <= wr_data[DIST_W-1:0];
                REG_UCUT:  ucut_reg  <= wr_data;
                REG_FCUT:  fcut_reg  <= wr_data;
                default:   ;
            endcase
        end
    end

    // the pipeline never stalls
    assign busy = 1'b0;

    // valid bits and side data travel together
    logic [ST_F:0] vld_reg;
    side_t         side_reg  [0:ST_F];
    side_t         side_next [0:ST_F];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[ST_F-1:0], start & ~busy};
    end

    // stage 0: classify distance, set up sigma/r, start cutoff term product
    logic [DIST_W+32:0]   num1;
    logic                 big1;
    logic [OUT_W-1:0]     fabs;
    logic [DIST_W-1:0]    rdiff;
    side_t                side_in;
    logic [RW-1:0]        d1_rem_reg, d1_den_reg;
    logic [QW-1:0]        d1_low_reg;
    logic [TPROD_W-1:0]   tprod_reg;

    always_comb
    begin
        num1  = {1'b0, sigma_reg, 32'd0} + (DIST_W + 33)'(pair_dist >> 1);
        big1  = DIST_W'(num1[DIST_W+32:QW]) >= pair_dist;
        fabs  = fcut_reg[OUT_W-1] ? OUT_W'(-fcut_reg) : OUT_W'(fcut_reg);
        rdiff = rcut_reg - pair_dist;
        side_in        = '0;
        side_in.r      = pair_dist;
        side_in.beyond = pair_dist > rcut_reg;
        side_in.zero   = pair_dist == '0;
        side_in.ovf    = big1;
    end

    always_ff @(posedge clk)
    begin
        d1_rem_reg <= RW'(num1[DIST_W+32:QW]);
        d1_low_reg <= num1[QW-1:0];
        d1_den_reg <= RW'(pair_dist);
        tprod_reg  <= TPROD_W'(rdiff) * TPROD_W'(fabs);
    end

    // stage 1: round the cutoff force term
    logic [TPROD_W:0]   tsum;
    logic signed [39:0] term1;

    always_comb
    begin
        tsum  = (TPROD_W + 1)'(tprod_reg) + T_HALF;
        term1 = $signed({1'b0, tsum[TPROD_W:DIST_FRAC]});
        if (fcut_reg > 0)
            term1 = -term1;
    end

    // s = sigma / r
    logic [QW-1:0] q1;

    ljsf_div u_div_s (
        .clk     (clk),
        .rem_in  (d1_rem_reg),
        .low_in  (d1_low_reg),
        .den_in  (d1_den_reg),
        .quo_out (q1),
        .rem_out ()
    );

    // power chain: s^2, s^4, s^6, s^12
    logic [PROD_W-1:0] p1, p2, p3, p4, p5, p6;
    logic [PROD_W-1:0] rnd1, rnd2, rnd3, rnd4;
    logic [39:0]       s2_reg;
    logic [47:0]       s4_reg;
    logic [55:0]       s6_reg;
    logic [62:0]       s12_reg;
    logic [39:0]       s2d_reg [0:DLY-1];
    logic [55:0]       s6d_reg [0:DLY-1];
    logic              ovf4;

    ljsf_mul u_mul_s2 (.clk(clk), .a(MUL_W'(q1)),     .b(MUL_W'(q1)),         .prod(p1));
    ljsf_mul u_mul_s4 (.clk(clk), .a(MUL_W'(s2_reg)), .b(MUL_W'(s2_reg)),     .prod(p2));
    ljsf_mul u_mul_s6 (.clk(clk), .a(MUL_W'(s4_reg)), .b(MUL_W'(s2d_reg[DLY-1])),
                       .prod(p3));
    ljsf_mul u_mul_sc (.clk(clk), .a(MUL_W'(s6_reg)), .b(MUL_W'(s6_reg)),     .prod(p4));

    assign rnd1 = p1 + Q32_HALF;
    assign rnd2 = p2 + Q32_HALF;
    assign rnd3 = p3 + Q32_HALF;
    assign rnd4 = p4 + Q32_HALF;
    assign ovf4 = |rnd4[PROD_W-1:95];

    // round each power to Q.32 and hold the factors that are used later
    always_ff @(posedge clk)
    begin
        s2_reg  <= rnd1[71:32];
        s4_reg  <= rnd2[79:32];
        s6_reg  <= rnd3[87:32];
        s12_reg <= rnd4[94:32];
        s2d_reg[0] <= s2_reg;
        s6d_reg[0] <= s6_reg;
        for (int i = 1; i < DLY; i++)
        begin
            s2d_reg[i] <= s2d_reg[i-1];
            s6d_reg[i] <= s6d_reg[i-1];
        end
    end

    // energy and force bracket terms
    logic [MUL_W-1:0]  s12x2;
    logic [MUL_W-1:0]  s6w;
    logic              uneg_dg, fneg_dg;
    logic [62:0]       diff_reg;
    logic [MUL_W-1:0]  g_reg;

    always_comb
    begin
        s12x2   = {s12_reg, 1'b0};
        s6w     = MUL_W'(s6d_reg[DLY-1]);
        uneg_dg = MUL_W'(s12_reg) < s6w;
        fneg_dg = s12x2 < s6w;
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= uneg_dg ? 63'(s6w - MUL_W'(s12_reg)) : 63'(MUL_W'(s12_reg) - s6w);
        g_reg    <= fneg_dg ? (s6w - s12x2) : (s12x2 - s6w);
    end

    // scale by epsilon
    logic [EPS_W+4:0] eps24;

    assign eps24 = {eps_reg, 4'b0} + {1'b0, eps_reg, 3'b0};

    ljsf_mul u_mul_u (.clk(clk), .a(MUL_W'({eps_reg, 2'b0})), .b(MUL_W'(diff_reg)),
                      .prod(p5));
    ljsf_mul u_mul_f (.clk(clk), .a(MUL_W'(eps24)), .b(g_reg), .prod(p6));

    // energy magnitude and force numerator setup
    logic [PROD_W-1:0]        urnd;
    logic [PROD_W-E_SHIFT-1:0] uq;
    logic [MAG_W-1:0]         umag_n;
    logic [RW-1:0]            den2;
    logic                     big2_n;
    logic [RW-1:0]            d2_rem_reg, d2_den_reg;
    logic [QW-1:0]            d2_low_reg;

    always_comb
    begin
        urnd   = p5 + E_HALF;
        uq     = urnd[PROD_W-1:E_SHIFT];
        umag_n = (uq > (PROD_W-E_SHIFT)'(MAG_CAP)) ? MAG_CAP : uq[MAG_W-1:0];
        den2   = {side_reg[ST_N-1].r, {F_SHIFT{1'b0}}};
        big2_n = p6[PROD_W-1:QW] >= (PROD_W-QW)'(den2);
    end

    always_ff @(posedge clk)
    begin
        d2_rem_reg <= p6[QW+RW-1:QW];
        d2_low_reg <= p6[QW-1:0];
        d2_den_reg <= den2;
    end

    // force quotient
    logic [QW-1:0] q2;
    logic [RW-1:0] rem2;

    ljsf_div u_div_f (
        .clk     (clk),
        .rem_in  (d2_rem_reg),
        .low_in  (d2_low_reg),
        .den_in  (d2_den_reg),
        .quo_out (q2),
        .rem_out (rem2)
    );

    // advance side data, fill in fields as they are produced
    always_comb
    begin
        side_next[0] = side_in;
        for (int i = 1; i <= ST_F; i++)
            side_next[i] = side_reg[i-1];
        side_next[1].term    = term1;
        side_next[ST_S12].ovf = side_reg[ST_S12-1].ovf | ovf4;
        side_next[ST_DG].uneg = uneg_dg;
        side_next[ST_DG].fneg = fneg_dg;
        side_next[ST_N].umag  = umag_n;
        side_next[ST_N].big2  = big2_n;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= ST_F; i++)
            side_reg[i] <= side_next[i];
    end

    // final: round force, combine, clip
    side_t                   sf;
    logic [RW-1:0]           denf;
    logic                    rnd_up;
    logic [FMAG_W-1:0]       fmag;
    logic [FMAG_W-1:0]       fmag_e;
    logic [MAG_W-1:0]        umag_e;
    logic signed [SUM_W-1:0] uval, fval, esum, fsum;
    clip_t                   ce, cf;

    always_comb
    begin
        sf     = side_reg[ST_F];
        denf   = {sf.r, {F_SHIFT{1'b0}}};
        rnd_up = {rem2, 1'b0} >= {1'b0, denf};
        fmag   = sf.big2 ? (FMAG_W'(1) << QW) : ({1'b0, q2} + FMAG_W'(rnd_up));
        umag_e = sf.ovf ? '0 : sf.umag;
        fmag_e = sf.ovf ? '0 : fmag;
        uval   = $signed(SUM_W'(umag_e));
        fval   = $signed(SUM_W'(fmag_e));
        if (sf.uneg)
            uval = -uval;
        if (sf.fneg)
            fval = -fval;
        esum = uval - SUM_W'(ucut_reg) + SUM_W'(sf.term);
        fsum = fval - SUM_W'(fcut_reg);
        ce   = sat32(esum);
        cf   = sat32(fsum);
    end

    // output registers
    logic                    done_reg;
    logic signed [OUT_W-1:0] energy_reg, force_reg;
    logic                    beyond_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[ST_F];
    end

    always_ff @(posedge clk)
    begin
        if (sf.beyond)
        begin
            energy_reg <= '0;
            force_reg  <= '0;
            beyond_reg <= 1'b1;
            sat_reg    <= 1'b0;
        end
        else if (sf.zero || (sf.ovf && eps_reg != '0))
        begin
            energy_reg <= 32'sh7FFFFFFF;
            force_reg  <= 32'sh7FFFFFFF;
            beyond_reg <= 1'b0;
            sat_reg    <= 1'b1;
        end
        else
        begin
            energy_reg <= ce.val;
            force_reg  <= cf.val;
            beyond_reg <= 1'b0;
            sat_reg    <= ce.sat | cf.sat;
        end
    end

    assign done       = done_reg;
    assign energy_out = energy_reg;
    assign force_out  = force_reg;
    assign beyond_cut = beyond_reg;
    assign saturated  = sat_reg;

    // checks
    `LJSF_ASSERT_IMP(a_beyond_zero, clk, rst_n, done && beyond_cut, energy_out == '0 && force_out == '0 && !saturated, "beyond cutoff result not zero")
    `LJSF_ASSERT_IMP(a_div_s_range, clk, rst_n, vld_reg[0] && !side_reg[0].ovf, d1_rem_reg < d1_den_reg, "sigma/r divider start remainder out of range")
    `LJSF_ASSERT_IMP(a_div_f_range, clk, rst_n, vld_reg[ST_N] && !side_reg[ST_N].big2, d2_rem_reg < d2_den_reg, "force divider start remainder out of range")
    `LJSF_ASSERT_NXT(a_sigma_wr, clk, rst_n, wr_en && wr_index == REG_SIGMA, sigma_reg == $past(wr_data[DIST_W-1:0]), "sigma write lost")

endmodule

### tb/lj_shifted_force_pair_tb.sv
// Self-checking testbench for the shifted-force Lennard-Jones pair evaluator.
`timescale 1ns / 100ps

module lj_shifted_force_pair_tb;
    import ljsf_pkg::*;

    localparam int          CLK_PERIOD  = 12;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 120;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic [63:0] FULL_CAP    = 64'd1 << 50;

    typedef struct packed {
        logic signed [OUT_W-1:0] energy;
        logic signed [OUT_W-1:0] force_val;
        logic                    beyond;
        logic                    sat;
    } pair_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start = 1'b0;
    logic                    busy;
    logic [DIST_W-1:0]       pair_dist = '0;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_index;
    logic [OUT_W-1:0]        wr_data;
    logic                    done;
    logic signed [OUT_W-1:0] energy_out;
    logic signed [OUT_W-1:0] force_out;
    logic                    beyond_cut;
    logic                    saturated;

    // predictor copy of the configuration registers
    logic [DIST_W-1:0]       cfg_sigma;
    logic [EPS_W-1:0]        cfg_eps;
    logic [DIST_W-1:0]       cfg_rcut;
    logic signed [OUT_W-1:0] cfg_ucut;
    logic signed [OUT_W-1:0] cfg_fcut;

    logic [DIST_W-1:0] pending_dist[$];
    pair_result_t      expected_pairs[$];
    logic              took = 1'b0;
    int                n_accepted = 0;
    int                idle_pct;
    int                errors = 0;
    int                cycles = 0;

    lj_shifted_force_pair u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pair_dist  (pair_dist),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .done       (done),
        .energy_out (energy_out),
        .force_out  (force_out),
        .beyond_cut (beyond_cut),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Q.32 product rounded to nearest; top bit flags overflow
    function automatic logic [64:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] w;
        w = 128'(a) * 128'(b) + (128'd1 << 31);
        if (w[127:96] != 0)
            return {1'b1, {64{1'b1}}};
        return {1'b0, w[95:32]};
    endfunction

    // clip to 32 bits; top bit flags a clip
    function automatic logic [32:0] clip_out(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return {1'b1, 32'h7FFFFFFF};
        if (v < -64'sd2147483648)
            return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    // compute the shifted-force energy and force for one distance
    function automatic pair_result_t lj_pair_eval(input logic [DIST_W-1:0] r);
        pair_result_t      o;
        logic [64:0]       t;
        logic [63:0]       s, s2, s4, s6, s12, umag, fmag, g, diff, fabs_cut, tmag;
        logic [127:0]      w, q, rem, d;
        logic              ovf, uneg, fneg;
        logic signed [63:0] fcut64, term, e, f;
        logic [32:0]       ce, cf;
        o = '0;
        if (r > cfg_rcut)
        begin
            o.beyond = 1'b1;
            return o;
        end
        if (r == 0)
        begin
            o.energy    = 32'sh7FFFFFFF;
            o.force_val = 32'sh7FFFFFFF;
            o.sat       = 1'b1;
            return o;
        end
        s = ((64'(cfg_sigma) << 32) + 64'(r >> 1)) / 64'(r);
        t = q32_mul(s, s);    ovf = t[64];       s2  = t[63:0];
        t = q32_mul(s2, s2);  ovf = ovf | t[64]; s4  = t[63:0];
        t = q32_mul(s4, s2);  ovf = ovf | t[64]; s6  = t[63:0];
        t = q32_mul(s6, s6);  ovf = ovf | t[64]; s12 = t[63:0];
        if (s12[63])
            ovf = 1'b1;
        if (ovf && cfg_eps != 0)
        begin
            o.energy    = 32'sh7FFFFFFF;
            o.force_val = 32'sh7FFFFFFF;
            o.sat       = 1'b1;
            return o;
        end
        umag = 0;
        fmag = 0;
        uneg = 1'b0;
        fneg = 1'b0;
        if (!ovf)
        begin
            uneg = s12 < s6;
            diff = uneg ? s6 - s12 : s12 - s6;
            w = 128'(cfg_eps) * 128'd4 * 128'(diff) + (128'd1 << (E_SHIFT - 1));
            if (w[127:(64 + E_SHIFT)] != 0)
                umag = FULL_CAP;
            else
                umag = (w[(63 + E_SHIFT):E_SHIFT] > FULL_CAP) ? FULL_CAP
                                                              : w[(63 + E_SHIFT):E_SHIFT];
            fneg = (s12 << 1) < s6;
            g = fneg ? s6 - (s12 << 1) : (s12 << 1) - s6;
            w = 128'(cfg_eps) * 128'd24 * 128'(g);
            d = 128'(r) << F_SHIFT;
            q = w / d;
            rem = w % d;
            if (rem >= d - rem)
                q = q + 1;
            fmag = (q > 128'(FULL_CAP)) ? FULL_CAP : q[63:0];
        end
        // linear shift term from the cutoff force
        diff = 64'(cfg_rcut) - 64'(r);
        fcut64 = cfg_fcut;
        fabs_cut = (fcut64 < 0) ? -fcut64 : fcut64;
        tmag = (diff * fabs_cut + (64'd1 << (DIST_FRAC - 1))) >> DIST_FRAC;
        term = (fcut64 > 0) ? -$signed(tmag) : $signed(tmag);
        e = (uneg ? -$signed(umag) : $signed(umag)) - 64'(cfg_ucut) + term;
        f = (fneg ? -$signed(fmag) : $signed(fmag)) - fcut64;
        ce = clip_out(e);
        cf = clip_out(f);
        o.energy    = ce[31:0];
        o.force_val = cf[31:0];
        o.sat       = ce[32] | cf[32];
        return o;
    endfunction

    // drive a distance from the pending queue, with random gaps until 940 distances are accepted
    always @(negedge clk)
    begin
        if (took)
            void'(pending_dist.pop_front());
        idle_pct = (n_accepted < 470) ? 30 : (n_accepted < 940) ? 47 : 0;
        if (rst_n && (pending_dist.size() > 0) &&
            ($urandom_range(99) >= idle_pct))
        begin
            start     <= 1'b1;
            pair_dist <= pending_dist[0];
        end
        else
            start <= 1'b0;
    end

    // record each accepted transaction and its expected result
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_pairs.push_back(lj_pair_eval(pair_dist));
            n_accepted <= n_accepted + 1;
            took <= 1'b1;
        end
        else
            took <= 1'b0;
    end

    // compare each result against the oldest expectation
    always @(posedge clk)
    begin
        pair_result_t exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_pairs.size() == 0)
            begin
                errors <= errors + 1;
                $display("%0t: unexpected result, energy %h force %h", $time,
                         energy_out, force_out);
            end
            else
            begin
                exp_r = expected_pairs.pop_front();
                if (exp_r.energy !== energy_out || exp_r.force_val !== force_out ||
                    exp_r.beyond !== beyond_cut || exp_r.sat !== saturated)
                begin
                    errors <= errors + 1;
                    if (errors < 40)
                        $display("%0t: mismatch, expected e=%h f=%h b=%b s=%b, got e=%h f=%h b=%b s=%b",
                                 $time, exp_r.energy, exp_r.force_val, exp_r.beyond, exp_r.sat,
                                 energy_out, force_out, beyond_cut, saturated);
                end
            end
        end
    end

    // write one register and mirror it in the predictor
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [OUT_W-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_SIGMA: cfg_sigma = val[DIST_W-1:0];
            REG_EPS:   cfg_eps   = val;
            REG_RCUT:  cfg_rcut  = val[DIST_W-1:0];
            REG_UCUT:  cfg_ucut  = val;
            REG_FCUT:  cfg_fcut  = val;
            default:   ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [23:0] sg, input logic [31:0] ep, input logic [23:0] rc,
                             input logic [31:0] uc, input logic [31:0] fc);
        write_reg(REG_SIGMA, 32'(sg));
        write_reg(REG_EPS, ep);
        write_reg(REG_RCUT, 32'(rc));
        write_reg(REG_UCUT, uc);
        write_reg(REG_FCUT, fc);
    endtask

    // hold off until the pipeline has drained
    task automatic drain();
        wait (pending_dist.size() == 0 && expected_pairs.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    // queue random distances, mostly across the well and out past the cutoff
    task automatic queue_random(input int n);
        int          k;
        int unsigned lo, hi, sel;
        for (k = 0; k < n; k++)
        begin
            sel = $urandom_range(99);
            lo  = (cfg_sigma * 3) / 4;
            hi  = 32'(cfg_rcut) + 32'(cfg_rcut) / 8;
            if (hi > 24'hFFFFFF)
                hi = 24'hFFFFFF;
            if (lo > hi)
                lo = 0;
            if (sel < 78)
                pending_dist.push_back(DIST_W'($urandom_range(hi, lo)));
            else if (sel < 90)
                pending_dist.push_back(DIST_W'($urandom));
            else if (sel < 96)
                pending_dist.push_back(DIST_W'($urandom_range(4096)));
            else
                pending_dist.push_back(DIST_W'(cfg_rcut + DIST_W'($urandom_range(2)) - 1));
        end
    endtask

    initial
    begin
        int ph;
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        cfg_sigma  = SIGMA_RST;
        cfg_eps    = EPS_RST;
        cfg_rcut   = RCUT_RST;
        cfg_ucut   = '0;
        cfg_fcut   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset defaults, field extremes and special distances
        pending_dist.push_back(24'd0);
        pending_dist.push_back(24'd1);
        pending_dist.push_back(24'hFFFFFF);
        pending_dist.push_back(RCUT_RST);
        pending_dist.push_back(RCUT_RST + 24'd1);
        pending_dist.push_back(SIGMA_RST);
        pending_dist.push_back(24'd294253);
        pending_dist.push_back(24'h0AAAAA);
        pending_dist.push_back(24'd131072);
        drain();

        // directed: shifted energy and force with realistic cutoff values
        write_all(24'd262144, 32'd16777216, 24'd655360, 32'hFFFFFC10, 32'h00000272);
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        pending_dist.push_back(24'd655360);
        pending_dist.push_back(24'd300000);
        pending_dist.push_back(24'd250000);
        pending_dist.push_back(24'd500000);
        drain();

        // directed: zero well depth turns overflow into plain shift terms
        write_all(24'd262144, 32'd0, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        pending_dist.push_back(24'd1);
        pending_dist.push_back(24'd1000);
        pending_dist.push_back(24'hFFFFFF);
        drain();

        // directed: zero sigma, then the register extremes
        write_all(24'd0, 32'hFFFFFFFF, 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        pending_dist.push_back(24'd1);
        pending_dist.push_back(24'h800000);
        drain();
        write_all(24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        pending_dist.push_back(24'hFFFFFF);
        pending_dist.push_back(24'hF00000);
        pending_dist.push_back(24'h555555);
        drain();
        write_all(24'd262144, 32'd16777216, 24'd0, 32'd0, 32'd0);
        pending_dist.push_back(24'd0);
        pending_dist.push_back(24'd1);
        drain();

        // random phases, each with its own setting
        for (ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                write_all(24'($urandom), $urandom, 24'($urandom), $urandom, $urandom);
            else
            begin
                write_all(24'($urandom_range(24'h60000, 24'h20000)),
                          (ph == 4) ? 32'd0 : $urandom_range(32'h08000000, 32'h00040000),
                          24'($urandom_range(24'hC0000, 24'h80000)),
                          32'($urandom_range(200000) - 100000),
                          32'($urandom_range(200000) - 100000));
            end
            queue_random(140);
            drain();
        end

        wait (expected_pairs.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
